// File: rtl/tzl_pkg.sv
// tzl_pkg: shared widths, command/status codes and control structs for the
// time zone transition lookup block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tzl_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 40;
    localparam int LOC_W  = KEY_W + 1;
    localparam int TIDX_W = 6;
    localparam int OFF_W  = 18;
    localparam int ABBR_W = 8;
    localparam int STAT_W = 2;

    // Stored words: type = {abbrev, dst, offset}, transition = {type, local, utc}
    localparam int TYPE_WORD_W  = ABBR_W + 1 + OFF_W;
    localparam int TRANS_WORD_W = TIDX_W + LOC_W + KEY_W;

    localparam logic [CMD_W-1:0] CMD_LOAD_TYPE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TRANS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_UTC   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_LOCAL = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_TYPE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_TYPE  = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input transaction
        logic decode;     // check tables, set status, write type entry, init search
        logic tr_wr;      // write transition entry
        logic probe_upd;  // apply one search compare
        logic sel_addr;   // type memory read at selected type
        logic conv;       // build lookup result
        logic push;       // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             tr_ok;
        logic             lookup_ok;
        logic             search_done;
        logic             out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/tzl_if.sv
// tzl_if: request and response channel interfaces (valid/ready + payload).
// Depends on tzl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tzl_req_if import tzl_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [KEY_W-1:0]  time_value;
    logic [TIDX_W-1:0]        type_index;
    logic signed [OFF_W-1:0]  utc_offset;
    logic                     dst_flag;
    logic [ABBR_W-1:0]        abbrev_index;

    modport source (output valid, command, time_value, type_index, utc_offset,
                    dst_flag, abbrev_index, input ready);
    modport sink   (input valid, command, time_value, type_index, utc_offset,
                    dst_flag, abbrev_index, output ready);
endinterface

interface tzl_rsp_if import tzl_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [OFF_W-1:0]  found_offset;
    logic                     found_dst;
    logic [ABBR_W-1:0]        found_abbrev;
    logic signed [KEY_W-1:0]  converted_time;

    modport source (output valid, status, found_offset, found_dst, found_abbrev,
                    converted_time, input ready);
    modport sink   (input valid, status, found_offset, found_dst, found_abbrev,
                    converted_time, output ready);
endinterface

`default_nettype wire

// File: rtl/time_zone_transition_lookup.sv
// time_zone_transition_lookup: top level joining tzl_ctrl and tzl_dpath.
// Depends on tzl_pkg, tzl_if, tzl_ram, tzl_ctrl, tzl_dpath.
//
// Usage:
//   i_req carries one command per transaction: load a type, load a transition,
//   or look up by UTC or by local seconds. o_rsp returns exactly one result
//   transaction per request, in order.
//   A lookup, once a type is loaded, is a binary search of at most
//   floor(log2(n)) + 1 probes over n stored transitions (none when empty).
//   Each probe is one registered read of the transition memory followed by
//   one compare.
//   One request is worked on at a time; i_req.ready rises again the cycle
//   after the result moves into the output register.
//   The output register decouples the sides: a new request is taken while a
//   finished result still waits on o_rsp. If o_rsp stalls, the next result
//   waits inside the block and no further request is taken.
//   Reset (synchronous, active low) empties both tables and the output
//   register; memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module time_zone_transition_lookup import tzl_pkg::*; #(
    parameter int TRANS_DEPTH = 256,
    parameter int TYPE_DEPTH  = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tzl_req_if.sink    i_req,
    tzl_rsp_if.source  o_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing: one request at a time, binary search with a read state and a compare state per probe
    tzl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // tables, search window, offset conversion, output register
    tzl_dpath #(
        .TRANS_DEPTH (TRANS_DEPTH),
        .TYPE_DEPTH  (TYPE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_command        (i_req.command),
        .i_time_value     (i_req.time_value),
        .i_type_index     (i_req.type_index),
        .i_utc_offset     (i_req.utc_offset),
        .i_dst_flag       (i_req.dst_flag),
        .i_abbrev_index   (i_req.abbrev_index),
        .o_valid          (o_rsp.valid),
        .i_ready          (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_found_offset   (o_rsp.found_offset),
        .o_found_dst      (o_rsp.found_dst),
        .o_found_abbrev   (o_rsp.found_abbrev),
        .o_converted_time (o_rsp.converted_time)
    );

endmodule

`default_nettype wire

// File: rtl/tzl_ram.sv
// tzl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tzl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/tzl_ctrl.sv
// tzl_ctrl: sequencing state machine for loads and binary-search lookups.
// Depends on tzl_pkg; drives tzl_dpath through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module tzl_ctrl import tzl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_TR_WR     = 3'd2;
    localparam logic [2:0] S_PROBE_RD  = 3'd3;
    localparam logic [2:0] S_PROBE_CMP = 3'd4;
    localparam logic [2:0] S_SEL_RD    = 3'd5;
    localparam logic [2:0] S_CONV      = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_stat.cmd)
                    CMD_LOAD_TYPE:  n_state = S_OUT;
                    CMD_LOAD_TRANS: n_state = i_stat.tr_ok ? S_TR_WR : S_OUT;
                    default:        n_state = i_stat.lookup_ok ? S_PROBE_RD : S_OUT;
                endcase
            end
            S_TR_WR: begin
                o_cmd.tr_wr = 1'b1;
                n_state     = S_OUT;
            end
            S_PROBE_RD: begin
                // read of mem[mid] is in flight unless the window is empty
                n_state = i_stat.search_done ? S_SEL_RD : S_PROBE_CMP;
            end
            S_PROBE_CMP: begin
                o_cmd.probe_upd = 1'b1;
                n_state         = S_PROBE_RD;
            end
            S_SEL_RD: begin
                o_cmd.sel_addr = 1'b1;
                n_state        = S_CONV;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tzl_dpath.sv
// tzl_dpath: type and transition tables, search window, conversion and
// output register. Depends on tzl_pkg and tzl_ram.
`timescale 1ns / 1ps
`default_nettype none

module tzl_dpath import tzl_pkg::*; #(
    parameter int TRANS_DEPTH = 256,
    parameter int TYPE_DEPTH  = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_stat                     o_stat,
    input  wire logic [CMD_W-1:0]        i_command,
    input  wire logic signed [KEY_W-1:0] i_time_value,
    input  wire logic [TIDX_W-1:0]       i_type_index,
    input  wire logic signed [OFF_W-1:0] i_utc_offset,
    input  wire logic                    i_dst_flag,
    input  wire logic [ABBR_W-1:0]       i_abbrev_index,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [STAT_W-1:0]            o_status,
    output logic signed [OFF_W-1:0]      o_found_offset,
    output logic                         o_found_dst,
    output logic [ABBR_W-1:0]            o_found_abbrev,
    output logic signed [KEY_W-1:0]      o_converted_time
);

    localparam int TRW  = $clog2(TRANS_DEPTH + 1);
    localparam int TRA  = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
    localparam int TYW  = $clog2(TYPE_DEPTH + 1);
    localparam int TYA  = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1;
    localparam int CMPW = (TYW > TIDX_W) ? TYW : TIDX_W;

    // captured transaction
    logic [CMD_W-1:0]        r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic [TIDX_W-1:0]       r_tidx;
    logic signed [OFF_W-1:0] r_off;
    logic                    r_dst;
    logic [ABBR_W-1:0]       r_abbr;

    logic [TYW-1:0]    r_type_cnt;
    logic [TRW-1:0]    r_trans_cnt;
    logic [TRW-1:0]    r_lo;
    logic [TRW-1:0]    r_hi;
    logic [TIDX_W-1:0] r_sel;

    logic [STAT_W-1:0]       r_res_status;
    logic signed [OFF_W-1:0] r_res_off;
    logic                    r_res_dst;
    logic [ABBR_W-1:0]       r_res_abbr;
    logic signed [KEY_W-1:0] r_res_conv;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic signed [OFF_W-1:0] r_out_off;
    logic                    r_out_dst;
    logic [ABBR_W-1:0]       r_out_abbr;
    logic signed [KEY_W-1:0] r_out_conv;

    logic type_full, trans_full, bad_type, no_type, sel_bad;
    logic [TRW:0]   mid_sum;
    logic [TRW-1:0] mid;
    logic [TRW-1:0] mid_inc;
    logic [TIDX_W-1:0] sel_idx;

    logic                    ty_we;
    logic [TYA-1:0]          ty_raddr;
    logic [TYPE_WORD_W-1:0]  ty_rdata;
    logic signed [OFF_W-1:0] ty_off;
    logic                    ty_dst;
    logic [ABBR_W-1:0]       ty_abbr;

    logic [TRANS_WORD_W-1:0] tr_wdata;
    logic [TRANS_WORD_W-1:0] tr_rdata;
    logic signed [KEY_W-1:0] tr_utc;
    logic signed [LOC_W-1:0] tr_local;
    logic [TIDX_W-1:0]       tr_type;

    logic signed [LOC_W-1:0] key_ext;
    logic signed [LOC_W-1:0] off_ext;
    logic signed [LOC_W-1:0] probe_tab;
    logic signed [LOC_W-1:0] new_local;
    logic signed [LOC_W-1:0] conv_sum;
    logic signed [KEY_W-1:0] conv_sat;
    logic                    probe_le;

    assign type_full  = (r_type_cnt == TYW'(TYPE_DEPTH));
    assign trans_full = (r_trans_cnt == TRW'(TRANS_DEPTH));
    assign no_type    = (r_type_cnt == '0);
    assign bad_type   = (CMPW'(r_tidx) >= CMPW'(r_type_cnt));
    assign sel_bad    = (CMPW'(r_sel) >= CMPW'(r_type_cnt));
    assign sel_idx    = sel_bad ? '0 : r_sel;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[TRW:1];
    assign mid_inc = mid + TRW'(1);

    // type table
    assign ty_we    = i_cmd.decode && (r_cmd == CMD_LOAD_TYPE) && !type_full;
    assign ty_raddr = i_cmd.sel_addr ? TYA'(sel_idx) : TYA'(r_tidx);
    assign ty_off   = ty_rdata[OFF_W-1:0];
    assign ty_dst   = ty_rdata[OFF_W];
    assign ty_abbr  = ty_rdata[OFF_W+1 +: ABBR_W];

    tzl_ram #(
        .WIDTH (TYPE_WORD_W),
        .DEPTH (TYPE_DEPTH)
    ) u_type_ram (
        .i_clk   (i_clk),
        .i_we    (ty_we),
        .i_waddr (r_type_cnt[TYA-1:0]),
        .i_wdata ({r_abbr, r_dst, r_off}),
        .i_raddr (ty_raddr),
        .o_rdata (ty_rdata)
    );

    // transition table
    assign key_ext   = {r_key[KEY_W-1], r_key};
    assign off_ext   = {{(LOC_W-OFF_W){ty_off[OFF_W-1]}}, ty_off};
    assign new_local = key_ext + off_ext;
    assign tr_wdata  = {r_tidx, new_local, r_key};
    assign tr_utc    = tr_rdata[KEY_W-1:0];
    assign tr_local  = tr_rdata[KEY_W +: LOC_W];
    assign tr_type   = tr_rdata[KEY_W+LOC_W +: TIDX_W];

    tzl_ram #(
        .WIDTH (TRANS_WORD_W),
        .DEPTH (TRANS_DEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tr_wr),
        .i_waddr (r_trans_cnt[TRA-1:0]),
        .i_wdata (tr_wdata),
        .i_raddr (mid[TRA-1:0]),
        .o_rdata (tr_rdata)
    );

    assign probe_tab = (r_cmd == CMD_LOOKUP_UTC) ? {tr_utc[KEY_W-1], tr_utc} : tr_local;
    assign probe_le  = (probe_tab <= key_ext);

    // key +/- offset, clamped to the 40-bit range
    assign conv_sum = (r_cmd == CMD_LOOKUP_UTC) ? (key_ext + off_ext) : (key_ext - off_ext);
    assign conv_sat = (conv_sum[LOC_W-1] != conv_sum[KEY_W-1]) ?
                      (conv_sum[LOC_W-1] ? KEY_MIN : KEY_MAX) : conv_sum[KEY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_key  <= i_time_value;
            r_tidx <= i_type_index;
            r_off  <= i_utc_offset;
            r_dst  <= i_dst_flag;
            r_abbr <= i_abbrev_index;
        end
        if (i_cmd.decode) begin
            r_lo       <= '0;
            r_hi       <= r_trans_cnt;
            r_sel      <= '0;
            r_res_off  <= '0;
            r_res_dst  <= 1'b0;
            r_res_abbr <= '0;
            r_res_conv <= '0;
            case (r_cmd)
                CMD_LOAD_TYPE:  r_res_status <= type_full ? STAT_FULL : STAT_OK;
                CMD_LOAD_TRANS: r_res_status <= bad_type ? STAT_BAD_TYPE :
                                                (trans_full ? STAT_FULL : STAT_OK);
                default:        r_res_status <= no_type ? STAT_NO_TYPE : STAT_OK;
            endcase
        end
        if (i_cmd.probe_upd) begin
            if (probe_le) begin
                r_lo  <= mid_inc;
                r_sel <= tr_type;
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.conv) begin
            r_res_off  <= ty_off;
            r_res_dst  <= ty_dst;
            r_res_abbr <= ty_abbr;
            r_res_conv <= conv_sat;
        end
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
            r_out_dst    <= r_res_dst;
            r_out_abbr   <= r_res_abbr;
            r_out_conv   <= r_res_conv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_cnt  <= '0;
            r_trans_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ty_we) begin
                r_type_cnt <= r_type_cnt + TYW'(1);
            end
            if (i_cmd.tr_wr) begin
                r_trans_cnt <= r_trans_cnt + TRW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.cmd         = r_cmd;
    assign o_stat.tr_ok       = !bad_type && !trans_full;
    assign o_stat.lookup_ok   = !no_type;
    assign o_stat.search_done = !(r_lo < r_hi);
    assign o_stat.out_free    = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_offset   = r_out_off;
    assign o_found_dst      = r_out_dst;
    assign o_found_abbrev   = r_out_abbr;
    assign o_converted_time = r_out_conv;

endmodule

`default_nettype wire

// File: rtl/tzl_checker.sv
// tzl_assertions: port-level assertions for time_zone_transition_lookup, bound
// to the top level. Depends on tzl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tzl_assertions import tzl_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [STAT_W-1:0]       i_status,
    input wire logic signed [OFF_W-1:0] i_found_offset,
    input wire logic                    i_found_dst,
    input wire logic [ABBR_W-1:0]       i_found_abbrev,
    input wire logic signed [KEY_W-1:0] i_converted_time
);

    logic       in_acc, out_acc;
    logic [1:0] r_open;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // transactions accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (in_acc && !out_acc) begin
            r_open <= r_open + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_open <= r_open - 2'd1;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_found_offset) && $stable(i_found_dst)
        && $stable(i_found_abbrev) && $stable(i_converted_time))
        else $error("response changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("request taken while previous one in progress");

    a_no_spurious_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 2'd0)
        else $error("response without an open request");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_open <= 2'd1)
        else $error("more than one request outstanding beside the output");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STAT_OK |-> i_found_offset == '0
        && !i_found_dst && i_found_abbrev == '0 && i_converted_time == '0)
        else $error("nonzero fields on an error status");

endmodule

bind time_zone_transition_lookup tzl_assertions u_tzl_assertions (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_found_offset   (o_rsp.found_offset),
    .i_found_dst      (o_rsp.found_dst),
    .i_found_abbrev   (o_rsp.found_abbrev),
    .i_converted_time (o_rsp.converted_time)
);

`default_nettype wire
